// ----- design/pngunf_pkg.sv -----
// Shared types and filter codes for the PNG row unfilter block.
package pngunf_pkg;

    localparam int PIXEL_BYTES = 4;
    localparam int PIXEL_W     = 8 * PIXEL_BYTES;

    localparam logic [7:0] FILTER_NONE  = 8'd0;
    localparam logic [7:0] FILTER_SUB   = 8'd1;
    localparam logic [7:0] FILTER_UP    = 8'd2;
    localparam logic [7:0] FILTER_AVG   = 8'd3;
    localparam logic [7:0] FILTER_PAETH = 8'd4;

    typedef struct packed {
        logic [7:0]         filter_type;
        logic [PIXEL_W-1:0] filtered_pixel;
        logic [PIXEL_W-1:0] above_pixel;
        logic               has_above;
        logic               row_start;
        logic               row_end;
    } filt_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] decoded_pixel;
        logic               bad_filter;
        logic               row_last;
    } dec_item_t;

endpackage

// ----- design/pngunf_lane.sv -----
// One byte lane of scanline reconstruction: predictor select and modulo-256 add.
module pngunf_lane
(
    input  logic [7:0] filter_type,
    input  logic [7:0] filt_byte,
    input  logic [7:0] left_byte,
    input  logic [7:0] up_byte,
    input  logic [7:0] ul_byte,
    output logic [7:0] dec_byte
);

    logic [8:0]        avg_sum;
    logic signed [9:0] pa_raw;
    logic signed [9:0] pb_raw;
    logic signed [9:0] pc_raw;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    assign avg_sum = {1'b0, left_byte} + {1'b0, up_byte};

    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    assign pa_raw = $signed({2'b00, up_byte}) - $signed({2'b00, ul_byte});
    assign pb_raw = $signed({2'b00, left_byte}) - $signed({2'b00, ul_byte});
    assign pc_raw = pa_raw + pb_raw;

    assign pa = pa_raw[9] ? 10'(-pa_raw) : 10'(pa_raw);
    assign pb = pb_raw[9] ? 10'(-pb_raw) : 10'(pb_raw);
    assign pc = pc_raw[9] ? 10'(-pc_raw) : 10'(pc_raw);

    always_comb
    begin
        if ((pa <= pb) && (pa <= pc))
        begin
            paeth = left_byte;
        end
        else if (pb <= pc)
        begin
            paeth = up_byte;
        end
        else
        begin
            paeth = ul_byte;
        end
    end

    always_comb
    begin
        unique case (filter_type)
            pngunf_pkg::FILTER_SUB:   pred = left_byte;
            pngunf_pkg::FILTER_UP:    pred = up_byte;
            pngunf_pkg::FILTER_AVG:   pred = avg_sum[8:1];
            pngunf_pkg::FILTER_PAETH: pred = paeth;
            default:                  pred = 8'd0;
        endcase
    end

    assign dec_byte = filt_byte + pred;

endmodule

// ----- design/png_row_unfilter_rgba8.sv -----
// Top level: PNG scanline reconstruction for RGBA8, one pixel per transfer.
// A pixel taken into the input register moves on to the result register, which drives dec_item.
// Throughput: one pixel per cycle while dec_ready is high; the left-pixel feedback passes through one register.
// An input register and a result register part the two sides, so while a result
// stalls, an empty input register can still take one more pixel.
// Reset: rst_n clears both valid flags and the left and upper-left pixels.
module png_row_unfilter_rgba8
#(
    parameter int BYTES_PER_PIXEL = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   filt_valid,
    output logic                   filt_ready,
    input  pngunf_pkg::filt_item_t filt_item,
    output logic                   dec_valid,
    input  logic                   dec_ready,
    output pngunf_pkg::dec_item_t  dec_item
);

    // Lanes beyond the field width do not exist; lanes at or above the
    // configured pixel size decode to zero.
    localparam int LANES = (BYTES_PER_PIXEL < pngunf_pkg::PIXEL_BYTES) ?
                           BYTES_PER_PIXEL : pngunf_pkg::PIXEL_BYTES;

    pngunf_pkg::filt_item_t in_item_reg;
    logic                   in_valid_reg;
    pngunf_pkg::dec_item_t  out_item_reg;
    pngunf_pkg::dec_item_t  out_item_next;
    logic                   out_valid_reg;

    logic [pngunf_pkg::PIXEL_W-1:0] left_pixel_reg;
    logic [pngunf_pkg::PIXEL_W-1:0] upper_left_reg;

    logic                           advance;
    logic                           bad;
    logic [pngunf_pkg::PIXEL_W-1:0] up_pix;
    logic [pngunf_pkg::PIXEL_W-1:0] left_pix;
    logic [pngunf_pkg::PIXEL_W-1:0] ul_pix;
    logic [pngunf_pkg::PIXEL_W-1:0] lanes_out;

    // Advance the held pixel into the result register when that register is
    // empty or its transfer completes this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || dec_ready);
    assign filt_ready = !in_valid_reg || advance;

    // Drop the neighbors that do not exist: no previous row zeroes up and
    // upper-left, a row start zeroes left and upper-left.
    assign up_pix   = in_item_reg.has_above ? in_item_reg.above_pixel : '0;
    assign left_pix = in_item_reg.row_start ? '0 : left_pixel_reg;
    assign ul_pix   = (in_item_reg.row_start || !in_item_reg.has_above) ?
                      '0 : upper_left_reg;
    assign bad      = in_item_reg.filter_type > pngunf_pkg::FILTER_PAETH;

    for (genvar lane = 0; lane < pngunf_pkg::PIXEL_BYTES; lane++)
    begin : g_lane
        if (lane < LANES)
        begin : g_active
            pngunf_lane u_lane
            (
                .filter_type (in_item_reg.filter_type),
                .filt_byte   (in_item_reg.filtered_pixel[8*lane +: 8]),
                .left_byte   (left_pix[8*lane +: 8]),
                .up_byte     (up_pix[8*lane +: 8]),
                .ul_byte     (ul_pix[8*lane +: 8]),
                .dec_byte    (lanes_out[8*lane +: 8])
            );
        end
        else
        begin : g_unused
            assign lanes_out[8*lane +: 8] = 8'd0;
        end
    end

    // An invalid filter yields a zero pixel, which also becomes the new left.
    always_comb
    begin
        out_item_next.decoded_pixel = bad ? '0 : lanes_out;
        out_item_next.bad_filter    = bad;
        out_item_next.row_last      = in_item_reg.row_end;
    end

    // Control and predictor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_pixel_reg <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            if (filt_ready)
            begin
                in_valid_reg <= filt_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                left_pixel_reg <= out_item_next.decoded_pixel;
                upper_left_reg <= up_pix;
            end
            else if (dec_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (filt_valid && filt_ready)
        begin
            in_item_reg <= filt_item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_item  = out_item_reg;

endmodule

// ----- design/pngunf_checker.sv -----
// Port-level checker for the PNG row unfilter block, with its bind.
module pngunf_checker
#(
    parameter int BYTES_PER_PIXEL = 4
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   filt_valid,
    input logic                   filt_ready,
    input pngunf_pkg::filt_item_t filt_item,
    input logic                   dec_valid,
    input logic                   dec_ready,
    input pngunf_pkg::dec_item_t  dec_item
);

    localparam int LANES = (BYTES_PER_PIXEL < pngunf_pkg::PIXEL_BYTES) ?
                           BYTES_PER_PIXEL : pngunf_pkg::PIXEL_BYTES;
    localparam int ZERO_BITS = 8 * (pngunf_pkg::PIXEL_BYTES - LANES);

    logic [pngunf_pkg::PIXEL_W-1:0] upper_mask;

    assign upper_mask = ~({pngunf_pkg::PIXEL_W{1'b1}} >> ZERO_BITS);

    // Hold a stalled result unchanged.
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(dec_item))
        else $error("stalled result changed or dropped");

    // An invalid filter must give a zero pixel.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_item.bad_filter |-> dec_item.decoded_pixel == '0)
        else $error("invalid filter produced nonzero pixel");

    // Lanes beyond the pixel size stay zero.
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid |-> (dec_item.decoded_pixel & upper_mask) == '0)
        else $error("unused lane nonzero");

endmodule

bind png_row_unfilter_rgba8 pngunf_checker #(.BYTES_PER_PIXEL(BYTES_PER_PIXEL)) u_checker (.*);
